@@ src/msc_pkg.sv @@
package msc_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int VALUE_BITS_DEF = 16;
    localparam int TAG_BITS       = 16;
    localparam int CASE_BITS      = 4;
    localparam int COUNT_BITS     = 2;
    localparam int LANES          = 4;
    localparam int FIFO_DEPTH     = 4;
    localparam int CFG_ADDR_BITS  = 3;
    localparam int CFG_DATA_BITS  = 32;

    // Reset value of the level threshold before it is cut to the value width.
    localparam logic [31:0] LEVEL_RESET_VAL = 32'd32768;

    // Register indexes, taken from the word address.
    localparam logic REG_LEVEL = 1'b0;
    localparam logic REG_FLOOR = 1'b1;

    // Edge points; each is also the divider lane that computes it.
    localparam logic [1:0] EP_TOP = 2'd0;
    localparam logic [1:0] EP_BOT = 2'd1;
    localparam logic [1:0] EP_LFT = 2'd2;
    localparam logic [1:0] EP_RGT = 2'd3;

    typedef struct packed {
        logic [COUNT_BITS-1:0] count;
        logic [1:0]            p0;
        logic [1:0]            p1;
        logic [1:0]            p2;
        logic [1:0]            p3;
    } seg_plan_t;

    // Segment endpoints by marching-squares case.
    function automatic seg_plan_t seg_plan(input logic [CASE_BITS-1:0] cs);
        seg_plan_t p;
        p = '{count: 2'd0, p0: EP_TOP, p1: EP_TOP, p2: EP_TOP, p3: EP_TOP};
        case (cs)
            4'd1, 4'd14: p = '{count: 2'd1, p0: EP_TOP, p1: EP_LFT, p2: EP_TOP, p3: EP_TOP};
            4'd2, 4'd13: p = '{count: 2'd1, p0: EP_TOP, p1: EP_RGT, p2: EP_TOP, p3: EP_TOP};
            4'd4, 4'd11: p = '{count: 2'd1, p0: EP_BOT, p1: EP_RGT, p2: EP_TOP, p3: EP_TOP};
            4'd7, 4'd8:  p = '{count: 2'd1, p0: EP_BOT, p1: EP_LFT, p2: EP_TOP, p3: EP_TOP};
            4'd3, 4'd12: p = '{count: 2'd1, p0: EP_LFT, p1: EP_RGT, p2: EP_TOP, p3: EP_TOP};
            4'd6, 4'd9:  p = '{count: 2'd1, p0: EP_TOP, p1: EP_BOT, p2: EP_TOP, p3: EP_TOP};
            4'd5:        p = '{count: 2'd2, p0: EP_TOP, p1: EP_RGT, p2: EP_BOT, p3: EP_LFT};
            4'd10:       p = '{count: 2'd2, p0: EP_TOP, p1: EP_LFT, p2: EP_BOT, p3: EP_RGT};
            default:     p.count = 2'd0;
        endcase
        return p;
    endfunction

endpackage

@@ src/msc_front.sv @@
module msc_front #(
    parameter int COORD_BITS = msc_pkg::COORD_BITS_DEF,
    parameter int VALUE_BITS = msc_pkg::VALUE_BITS_DEF
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       in_valid,
    output logic                                       in_ready,
    input  logic [msc_pkg::TAG_BITS-1:0]               in_tag,
    input  logic [msc_pkg::LANES-1:0][VALUE_BITS-1:0]  in_value,  // TL, TR, BR, BL
    input  logic [3:0][COORD_BITS-1:0]                 in_coord,  // lx, rx, ty, by
    input  logic [VALUE_BITS-1:0]                      level_threshold,
    input  logic [VALUE_BITS:0]                        weight_floor,
    output logic                                       out_valid,
    input  logic                                       out_ready,
    output logic [msc_pkg::TAG_BITS-1:0]               out_tag,
    output logic [msc_pkg::CASE_BITS-1:0]              out_case,
    output logic [3:0][COORD_BITS-1:0]                 out_coord,
    output logic [msc_pkg::LANES-1:0][COORD_BITS-1:0]  out_lo,
    output logic [msc_pkg::LANES-1:0][COORD_BITS+VALUE_BITS+2:0] out_num,
    output logic [msc_pkg::LANES-1:0][VALUE_BITS+1:0]  out_den
);
    import msc_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int V  = VALUE_BITS;
    localparam int NW = C + V + 3;
    localparam int DW = V + 2;
    localparam int PW = C + V + 2;

    logic                          en;
    logic [LANES-1:0][C-1:0]       ca, cb;
    logic [LANES-1:0][V-1:0]       wa, wb;
    logic [CASE_BITS-1:0]          cs;
    logic [LANES-1:0][C-1:0]       lo_c;
    logic [LANES-1:0][C:0]         d_c;
    logic [LANES-1:0][V:0]         whi_c, sum_c;
    logic [LANES-1:0]              light_c;

    logic                          f1_valid_reg;
    logic [TAG_BITS-1:0]           f1_tag_reg;
    logic [CASE_BITS-1:0]          f1_case_reg;
    logic [3:0][C-1:0]             f1_coord_reg;
    logic [LANES-1:0][C-1:0]       f1_lo_reg;
    logic [LANES-1:0][C:0]         f1_d_reg;
    logic [LANES-1:0][V:0]         f1_whi_reg, f1_sum_reg;
    logic [LANES-1:0]              f1_light_reg;

    logic [LANES-1:0][NW-1:0]      num_c;
    logic [LANES-1:0][DW-1:0]      den_c;
    logic [LANES-1:0][PW-1:0]      prod_c;

    logic                          f2_valid_reg;

    assign en       = !(f2_valid_reg && !out_ready);
    assign in_ready = en;

    always_comb begin
        ca[EP_TOP] = in_coord[0]; wa[EP_TOP] = in_value[0];
        cb[EP_TOP] = in_coord[1]; wb[EP_TOP] = in_value[1];
        ca[EP_BOT] = in_coord[0]; wa[EP_BOT] = in_value[3];
        cb[EP_BOT] = in_coord[1]; wb[EP_BOT] = in_value[2];
        ca[EP_LFT] = in_coord[2]; wa[EP_LFT] = in_value[0];
        cb[EP_LFT] = in_coord[3]; wb[EP_LFT] = in_value[3];
        ca[EP_RGT] = in_coord[2]; wa[EP_RGT] = in_value[1];
        cb[EP_RGT] = in_coord[3]; wb[EP_RGT] = in_value[2];
        cs[0] = in_value[0] >= level_threshold;
        cs[1] = in_value[1] >= level_threshold;
        cs[2] = in_value[2] >= level_threshold;
        cs[3] = in_value[3] >= level_threshold;
        for (int l = 0; l < LANES; l++) begin
            sum_c[l] = {1'b0, wa[l]} + {1'b0, wb[l]};
            light_c[l] = (sum_c[l] == '0) || (sum_c[l] < weight_floor);
            if ($signed(ca[l]) <= $signed(cb[l])) begin
                lo_c[l]  = ca[l];
                d_c[l]   = {cb[l][C-1], cb[l]} - {ca[l][C-1], ca[l]};
                whi_c[l] = {1'b0, wb[l]};
            end else begin
                lo_c[l]  = cb[l];
                d_c[l]   = {ca[l][C-1], ca[l]} - {cb[l][C-1], cb[l]};
                whi_c[l] = {1'b0, wa[l]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_valid_reg <= 1'b0;
        end else if (en) begin
            f1_valid_reg <= in_valid;
        end
        if (en) begin
            f1_tag_reg   <= in_tag;
            f1_case_reg  <= cs;
            f1_coord_reg <= in_coord;
            f1_lo_reg    <= lo_c;
            f1_d_reg     <= d_c;
            f1_whi_reg   <= whi_c;
            f1_sum_reg   <= sum_c;
            f1_light_reg <= light_c;
        end
    end

    // Rounded mean offset is floor((2*d*whi + sum) / (2*sum)); light lanes
    // divide d/2 by one so the divider yields the plain midpoint offset.
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            prod_c[l] = PW'(f1_d_reg[l]) * PW'(f1_whi_reg[l]);
            if (f1_light_reg[l]) begin
                num_c[l] = NW'(f1_d_reg[l] >> 1);
                den_c[l] = DW'(1);
            end else begin
                num_c[l] = {prod_c[l], 1'b0} + NW'(f1_sum_reg[l]);
                den_c[l] = {f1_sum_reg[l], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f2_valid_reg <= 1'b0;
        end else if (en) begin
            f2_valid_reg <= f1_valid_reg;
        end
        if (en) begin
            out_tag   <= f1_tag_reg;
            out_case  <= f1_case_reg;
            out_coord <= f1_coord_reg;
            out_lo    <= f1_lo_reg;
            out_num   <= num_c;
            out_den   <= den_c;
        end
    end

    assign out_valid = f2_valid_reg;

endmodule

@@ src/msc_fifo.sv @@
module msc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = msc_pkg::FIFO_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push, do_pop;

    assign full    = count_reg == CW'(DEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
        if (do_push) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ src/msc_back.sv @@
module msc_back #(
    parameter int COORD_BITS = msc_pkg::COORD_BITS_DEF,
    parameter int VALUE_BITS = msc_pkg::VALUE_BITS_DEF,
    parameter int OUT_BITS   = 280
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       in_valid,
    output logic                                       in_pop,
    input  logic [msc_pkg::TAG_BITS-1:0]               in_tag,
    input  logic [msc_pkg::CASE_BITS-1:0]              in_case,
    input  logic [3:0][COORD_BITS-1:0]                 in_coord,
    input  logic [msc_pkg::LANES-1:0][COORD_BITS-1:0]  in_lo,
    input  logic [msc_pkg::LANES-1:0][COORD_BITS+VALUE_BITS+2:0] in_num,
    input  logic [msc_pkg::LANES-1:0][VALUE_BITS+1:0]  in_den,
    output logic                                       m_tvalid,
    input  logic                                       m_tready,
    output logic [OUT_BITS-1:0]                        m_tdata
);
    import msc_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int V  = VALUE_BITS;
    localparam int DW = V + 2;
    localparam int S  = C + 1;   // one quotient bit per stage

    logic en;

    logic                          vld_reg   [S];
    logic [TAG_BITS-1:0]           tag_reg   [S];
    logic [CASE_BITS-1:0]          case_reg  [S];
    logic [3:0][C-1:0]             coord_reg [S];
    logic [LANES-1:0][C-1:0]       lo_reg    [S];
    logic [LANES-1:0][DW-1:0]      den_reg   [S];
    logic [LANES-1:0][DW-1:0]      rem_reg   [S];
    logic [LANES-1:0][C:0]         nq_reg    [S];

    logic [LANES-1:0][DW-1:0]      src_rem   [S];
    logic [LANES-1:0][C:0]         src_nq    [S];
    logic [LANES-1:0][DW-1:0]      src_den   [S];
    logic [LANES-1:0][DW-1:0]      rem_next  [S];
    logic [LANES-1:0][C:0]         nq_next   [S];

    assign en     = !m_tvalid || m_tready;
    assign in_pop = en;

    for (genvar k = 0; k < S; k++) begin : g_stage
        logic                    vld_in;
        logic [TAG_BITS-1:0]     tag_in;
        logic [CASE_BITS-1:0]    case_in;
        logic [3:0][C-1:0]       coord_in;
        logic [LANES-1:0][C-1:0] lo_in;

        if (k == 0) begin : g_head
            always_comb begin
                vld_in   = in_valid;
                tag_in   = in_tag;
                case_in  = in_case;
                coord_in = in_coord;
                lo_in    = in_lo;
                for (int l = 0; l < LANES; l++) begin
                    src_rem[k][l] = in_num[l][C+V+2:C+1];
                    src_nq[k][l]  = in_num[l][C:0];
                end
                src_den[k] = in_den;
            end
        end else begin : g_tail
            always_comb begin
                vld_in     = vld_reg[k-1];
                tag_in     = tag_reg[k-1];
                case_in    = case_reg[k-1];
                coord_in   = coord_reg[k-1];
                lo_in      = lo_reg[k-1];
                src_rem[k] = rem_reg[k-1];
                src_nq[k]  = nq_reg[k-1];
                src_den[k] = den_reg[k-1];
            end
        end

        always_comb begin
            logic [DW:0] t;
            for (int l = 0; l < LANES; l++) begin
                t = {src_rem[k][l], src_nq[k][l][C]};
                if (t >= {1'b0, src_den[k][l]}) begin
                    t = t - {1'b0, src_den[k][l]};
                    nq_next[k][l] = {src_nq[k][l][C-1:0], 1'b1};
                end else begin
                    nq_next[k][l] = {src_nq[k][l][C-1:0], 1'b0};
                end
                rem_next[k][l] = t[DW-1:0];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_in;
            end
            if (en) begin
                tag_reg[k]   <= tag_in;
                case_reg[k]  <= case_in;
                coord_reg[k] <= coord_in;
                lo_reg[k]    <= lo_in;
                den_reg[k]   <= src_den[k];
                rem_reg[k]   <= rem_next[k];
                nq_reg[k]    <= nq_next[k];
            end
        end
    end

    // Result assembly from the last divider stage.
    seg_plan_t               plan;
    logic [LANES-1:0][C-1:0] res;
    logic [3:0][C-1:0]       ex, ey;
    logic [3:0][1:0]         pts;
    logic [7:0][C-1:0]       seg;

    always_comb begin
        plan = seg_plan(case_reg[S-1]);
        for (int l = 0; l < LANES; l++) begin
            res[l] = lo_reg[S-1][l] + nq_reg[S-1][l][C-1:0];
        end
        ex[EP_TOP] = res[EP_TOP];          ey[EP_TOP] = coord_reg[S-1][2];
        ex[EP_BOT] = res[EP_BOT];          ey[EP_BOT] = coord_reg[S-1][3];
        ex[EP_LFT] = coord_reg[S-1][0];    ey[EP_LFT] = res[EP_LFT];
        ex[EP_RGT] = coord_reg[S-1][1];    ey[EP_RGT] = res[EP_RGT];
        pts = {plan.p3, plan.p2, plan.p1, plan.p0};
        for (int i = 0; i < 4; i++) begin
            if (3'(i) < {plan.count, 1'b0}) begin
                seg[2*i]   = ex[pts[i]];
                seg[2*i+1] = ey[pts[i]];
            end else begin
                seg[2*i]   = '0;
                seg[2*i+1] = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid <= 1'b0;
        end else if (en) begin
            m_tvalid <= vld_reg[S-1];
        end
        if (en) begin
            m_tdata <= OUT_BITS'({seg, plan.count, case_reg[S-1], tag_reg[S-1]});
        end
    end

endmodule

@@ src/marching_squares_cell_segments_top.sv @@
// Path: an accepted cell passes two front registers, the queue, one divider stage
// per quotient bit, and the output register.
// Throughput: one cell per cycle while back-pressure does not fill the queue; the four-lane divider is fully pipelined.
// Reset: aresetn is synchronous and active low; it empties the pipeline and the
// queue and loads level_threshold with 32768 and weight_floor with 1.
module marching_squares_cell_segments_top #(
    parameter int COORD_BITS = msc_pkg::COORD_BITS_DEF,
    parameter int VALUE_BITS = msc_pkg::VALUE_BITS_DEF,
    localparam int IN_RAW  = msc_pkg::TAG_BITS + 4 * VALUE_BITS + 4 * COORD_BITS,
    localparam int IN_BITS = ((IN_RAW + 7) / 8) * 8,
    localparam int OUT_RAW = msc_pkg::TAG_BITS + msc_pkg::CASE_BITS
                             + msc_pkg::COUNT_BITS + 8 * COORD_BITS,
    localparam int OUT_BITS = ((OUT_RAW + 7) / 8) * 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Cell input stream.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // From bit 0: cell_tag, value_top_left, value_top_right, value_bottom_right,
    // value_bottom_left, left_x, right_x, top_y, bottom_y, zero fill.
    input  logic [IN_BITS-1:0]                 s_tdata,
    // Segment result stream.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // From bit 0: tag_out, case_index, segment_count, first_start_x, first_start_y,
    // first_end_x, first_end_y, second_start_x, second_start_y, second_end_x,
    // second_end_y, zero fill.
    output logic [OUT_BITS-1:0]                m_tdata,
    // Configuration port.
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [msc_pkg::CFG_ADDR_BITS-1:0]  paddr,
    input  logic [msc_pkg::CFG_DATA_BITS-1:0]  pwdata,
    output logic [msc_pkg::CFG_DATA_BITS-1:0]  prdata,
    output logic                               pready
);
    import msc_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int V  = VALUE_BITS;
    localparam int NW = C + V + 3;
    localparam int DW = V + 2;
    localparam int QW = TAG_BITS + CASE_BITS + 4 * C + LANES * (C + NW + DW);

    // Configuration registers. A write lands on the access cycle; the word
    // address bit selects the register and the low address bits are ignored.
    logic [V-1:0] level_reg;
    logic [V:0]   floor_reg;
    logic         cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg <= LEVEL_RESET_VAL[V-1:0];
            floor_reg <= (V + 1)'(1);
        end else if (cfg_wr) begin
            if (paddr[2] == REG_LEVEL) begin
                level_reg <= pwdata[V-1:0];
            end else begin
                floor_reg <= pwdata[V:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_FLOOR) ? CFG_DATA_BITS'(floor_reg)
                                            : CFG_DATA_BITS'(level_reg);

    // Input unpacking.
    logic [TAG_BITS-1:0]      in_tag;
    logic [LANES-1:0][V-1:0]  in_value;
    logic [3:0][C-1:0]        in_coord;

    assign in_tag      = s_tdata[TAG_BITS-1:0];
    assign in_value[0] = s_tdata[TAG_BITS +: V];
    assign in_value[1] = s_tdata[TAG_BITS + V +: V];
    assign in_value[2] = s_tdata[TAG_BITS + 2*V +: V];
    assign in_value[3] = s_tdata[TAG_BITS + 3*V +: V];
    assign in_coord[0] = s_tdata[TAG_BITS + 4*V +: C];
    assign in_coord[1] = s_tdata[TAG_BITS + 4*V + C +: C];
    assign in_coord[2] = s_tdata[TAG_BITS + 4*V + 2*C +: C];
    assign in_coord[3] = s_tdata[TAG_BITS + 4*V + 3*C +: C];

    // The front classifies the cell, orders each edge's coordinates and forms
    // the dividend and divisor of every edge point.
    logic                     f_valid;
    logic [TAG_BITS-1:0]      f_tag;
    logic [CASE_BITS-1:0]     f_case;
    logic [3:0][C-1:0]        f_coord;
    logic [LANES-1:0][C-1:0]  f_lo;
    logic [LANES-1:0][NW-1:0] f_num;
    logic [LANES-1:0][DW-1:0] f_den;
    logic                     q_full, q_empty, q_pop;
    logic [QW-1:0]            q_wr, q_rd;

    msc_front #(.COORD_BITS(C), .VALUE_BITS(V)) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .in_tag          (in_tag),
        .in_value        (in_value),
        .in_coord        (in_coord),
        .level_threshold (level_reg),
        .weight_floor    (floor_reg),
        .out_valid       (f_valid),
        .out_ready       (!q_full),
        .out_tag         (f_tag),
        .out_case        (f_case),
        .out_coord       (f_coord),
        .out_lo          (f_lo),
        .out_num         (f_num),
        .out_den         (f_den)
    );

    // A short queue lets the front keep taking cells while the output stalls.
    assign q_wr = {f_tag, f_case, f_coord, f_lo, f_num, f_den};

    msc_fifo #(.WIDTH(QW), .DEPTH(FIFO_DEPTH)) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (f_valid),
        .wr_data (q_wr),
        .pop     (q_pop),
        .rd_data (q_rd),
        .full    (q_full),
        .empty   (q_empty)
    );

    logic [TAG_BITS-1:0]      b_tag;
    logic [CASE_BITS-1:0]     b_case;
    logic [3:0][C-1:0]        b_coord;
    logic [LANES-1:0][C-1:0]  b_lo;
    logic [LANES-1:0][NW-1:0] b_num;
    logic [LANES-1:0][DW-1:0] b_den;

    assign {b_tag, b_case, b_coord, b_lo, b_num, b_den} = q_rd;

    // The back runs four restoring dividers in lockstep, one quotient bit per
    // stage, then builds the segments; its output register doubles as the skid.
    msc_back #(.COORD_BITS(C), .VALUE_BITS(V), .OUT_BITS(OUT_BITS)) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (!q_empty),
        .in_pop   (q_pop),
        .in_tag   (b_tag),
        .in_case  (b_case),
        .in_coord (b_coord),
        .in_lo    (b_lo),
        .in_num   (b_num),
        .in_den   (b_den),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

@@ src/msc_checker.sv @@
module msc_checker #(
    parameter int COORD_BITS = msc_pkg::COORD_BITS_DEF,
    localparam int OUT_RAW = msc_pkg::TAG_BITS + msc_pkg::CASE_BITS
                             + msc_pkg::COUNT_BITS + 8 * COORD_BITS,
    localparam int OUT_BITS = ((OUT_RAW + 7) / 8) * 8
) (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [OUT_BITS-1:0]                m_tdata
);
    import msc_pkg::*;

    logic [CASE_BITS-1:0]  cs;
    logic [COUNT_BITS-1:0] cnt;

    assign cs  = m_tdata[TAG_BITS +: CASE_BITS];
    assign cnt = m_tdata[TAG_BITS + CASE_BITS +: COUNT_BITS];

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_empty_case: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (cs == 4'd0 || cs == 4'd15) |-> cnt == 2'd0)
        else $error("segments reported for a uniform cell");

    a_saddle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (cs == 4'd5 || cs == 4'd10) |-> cnt == 2'd2)
        else $error("saddle cell without two segments");

    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && cs != 4'd0 && cs != 4'd15 && cs != 4'd5 && cs != 4'd10
        |-> cnt == 2'd1)
        else $error("edge cell without exactly one segment");

endmodule

bind marching_squares_cell_segments_top msc_checker #(
    .COORD_BITS (COORD_BITS)
) u_msc_checker (.*);

@@ sim/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import msc_pkg::*;

    localparam int CB = 32;
    localparam int VB = 16;
    localparam int IN_BITS = 16 + 4 * VB + 4 * CB;
    localparam int OUT_BITS = ((16 + 4 + 2 + 8 * CB + 7) / 8) * 8;
    localparam int LATENCY = CB + 4;
    localparam int WATCHDOG_LIMIT = 20000;

    // Register byte addresses: register i sits at 4*i.
    localparam logic [CFG_ADDR_BITS-1:0] ADDR_LEVEL = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] ADDR_FLOOR = 3'd4;

    typedef struct packed {
        logic [CB-1:0] bottom_y;
        logic [CB-1:0] top_y;
        logic [CB-1:0] right_x;
        logic [CB-1:0] left_x;
        logic [VB-1:0] v_bl;
        logic [VB-1:0] v_br;
        logic [VB-1:0] v_tr;
        logic [VB-1:0] v_tl;
        logic [15:0]   tag;
    } cell_t;

    typedef struct packed {
        logic [CB-1:0] s1_ey;
        logic [CB-1:0] s1_ex;
        logic [CB-1:0] s1_sy;
        logic [CB-1:0] s1_sx;
        logic [CB-1:0] s0_ey;
        logic [CB-1:0] s0_ex;
        logic [CB-1:0] s0_sy;
        logic [CB-1:0] s0_sx;
        logic [1:0]    count;
        logic [3:0]    cs;
        logic [15:0]   tag;
    } segs_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_BITS-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_BITS-1:0] m_tdata;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [CFG_ADDR_BITS-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    marching_squares_cell_segments_top u_top (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready,
        .m_tdata, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Predictor copy of the two registers.
    logic [VB-1:0] level_q = 16'd32768;
    logic [VB:0]   floor_q = 17'd1;

    cell_t cells_pending[$];
    segs_t segs_expected[$];
    int errors = 0;
    int cells_sent = 0;
    int segs_checked = 0;
    int saddles_seen = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_cycles = 0;
    int idle_cycles = 0;
    bit timed_out = 1'b0;
    bit in_taken = 1'b0;

    // Value-weighted mean of two signed coordinates, rounded half up.
    function automatic logic [CB-1:0] edge_mean(logic [CB-1:0] ca, logic [VB-1:0] wa,
                                                logic [CB-1:0] cb, logic [VB-1:0] wb);
        longint a, b, lo;
        longint unsigned d, whi, s, q, r, off;
        a = longint'(signed'(ca));
        b = longint'(signed'(cb));
        s = longint'(wa) + longint'(wb);
        if (a <= b) begin
            lo = a; d = b - a; whi = wb;
        end else begin
            lo = b; d = a - b; whi = wa;
        end
        if (s == 0 || s < floor_q) begin
            off = d >> 1;
        end else begin
            q = d / s;
            r = d % s;
            off = q * whi + (2 * r * whi + s) / (2 * s);
        end
        return CB'(lo + longint'(off));
    endfunction

    function automatic segs_t cell_segments(cell_t c);
        segs_t o;
        logic [CB-1:0] px[4], py[4];
        logic [1:0] pt[4];
        logic [3:0] cs;
        int n;
        cs = {c.v_bl >= level_q, c.v_br >= level_q, c.v_tr >= level_q,
              c.v_tl >= level_q};
        px[EP_TOP] = edge_mean(c.left_x, c.v_tl, c.right_x, c.v_tr);
        py[EP_TOP] = c.top_y;
        px[EP_BOT] = edge_mean(c.left_x, c.v_bl, c.right_x, c.v_br);
        py[EP_BOT] = c.bottom_y;
        px[EP_LFT] = c.left_x;
        py[EP_LFT] = edge_mean(c.top_y, c.v_tl, c.bottom_y, c.v_bl);
        px[EP_RGT] = c.right_x;
        py[EP_RGT] = edge_mean(c.top_y, c.v_tr, c.bottom_y, c.v_br);
        n = 1;
        pt = '{EP_TOP, EP_TOP, EP_TOP, EP_TOP};
        case (cs)
            4'd1, 4'd14: begin
                pt[0] = EP_TOP; pt[1] = EP_LFT;
            end
            4'd2, 4'd13: begin
                pt[0] = EP_TOP; pt[1] = EP_RGT;
            end
            4'd4, 4'd11: begin
                pt[0] = EP_BOT; pt[1] = EP_RGT;
            end
            4'd7, 4'd8: begin
                pt[0] = EP_BOT; pt[1] = EP_LFT;
            end
            4'd3, 4'd12: begin
                pt[0] = EP_LFT; pt[1] = EP_RGT;
            end
            4'd6, 4'd9: begin
                pt[0] = EP_TOP; pt[1] = EP_BOT;
            end
            4'd5: begin
                pt = '{EP_TOP, EP_RGT, EP_BOT, EP_LFT}; n = 2;
            end
            4'd10: begin
                pt = '{EP_TOP, EP_LFT, EP_BOT, EP_RGT}; n = 2;
            end
            default: n = 0;
        endcase
        o = '0;
        o.tag = c.tag;
        o.cs = cs;
        o.count = 2'(n);
        if (n >= 1) begin
            o.s0_sx = px[pt[0]]; o.s0_sy = py[pt[0]];
            o.s0_ex = px[pt[1]]; o.s0_ey = py[pt[1]];
        end
        if (n == 2) begin
            o.s1_sx = px[pt[2]]; o.s1_sy = py[pt[2]];
            o.s1_ex = px[pt[3]]; o.s1_ey = py[pt[3]];
        end
        return o;
    endfunction

    // Records whether the offered cell went through at this rising edge.
    always @(posedge aclk) begin
        in_taken <= s_tvalid && s_tready;
    end

    // Driver: offers the oldest pending cell and drives m_tready; the prediction is made on transfer.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (in_taken) begin
                segs_expected.push_back(cell_segments(cells_pending.pop_front()));
                cells_sent++;
            end
            if (cells_pending.size() > 0 && (s_tvalid && !in_taken ||
                    $urandom_range(99) >= send_idle_pct)) begin
                s_tvalid <= 1'b1;
                s_tdata <= cells_pending[0];
            end else begin
                s_tvalid <= 1'b0;
            end
            if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= $urandom_range(99) >= recv_idle_pct;
            end
        end
    end

    // Monitor: checks each result transfer against the oldest expectation.
    always @(posedge aclk) begin
        segs_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[$bits(segs_t)-1:0];
            if (segs_expected.size() == 0) begin
                $error("result with no cell pending: tag %0d", got.tag);
                errors++;
            end else begin
                want = segs_expected.pop_front();
                segs_checked++;
                if (want.count == 2) saddles_seen++;
                if (got.tag !== want.tag) begin
                    $error("tag_out exp %0h got %0h", want.tag, got.tag); errors++;
                end
                if (got.cs !== want.cs) begin
                    $error("case_index exp %0d got %0d", want.cs, got.cs); errors++;
                end
                if (got.count !== want.count) begin
                    $error("segment_count exp %0d got %0d", want.count, got.count);
                    errors++;
                end
                if (got.s0_sx !== want.s0_sx) begin
                    $error("first_start_x exp %0h got %0h", want.s0_sx, got.s0_sx);
                    errors++;
                end
                if (got.s0_sy !== want.s0_sy) begin
                    $error("first_start_y exp %0h got %0h", want.s0_sy, got.s0_sy);
                    errors++;
                end
                if (got.s0_ex !== want.s0_ex) begin
                    $error("first_end_x exp %0h got %0h", want.s0_ex, got.s0_ex);
                    errors++;
                end
                if (got.s0_ey !== want.s0_ey) begin
                    $error("first_end_y exp %0h got %0h", want.s0_ey, got.s0_ey);
                    errors++;
                end
                if (got.s1_sx !== want.s1_sx) begin
                    $error("second_start_x exp %0h got %0h", want.s1_sx, got.s1_sx);
                    errors++;
                end
                if (got.s1_sy !== want.s1_sy) begin
                    $error("second_start_y exp %0h got %0h", want.s1_sy, got.s1_sy);
                    errors++;
                end
                if (got.s1_ex !== want.s1_ex) begin
                    $error("second_end_x exp %0h got %0h", want.s1_ex, got.s1_ex);
                    errors++;
                end
                if (got.s1_ey !== want.s1_ey) begin
                    $error("second_end_y exp %0h got %0h", want.s1_ey, got.s1_ey);
                    errors++;
                end
            end
        end
    end

    // Watchdog: cycles in which neither stream moves a transfer.
    always @(posedge aclk) begin
        if (aresetn && !(s_tvalid && s_tready) && !(m_tvalid && m_tready)) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) timed_out <= 1'b1;
        end else begin
            idle_cycles <= 0;
        end
    end

    task automatic reg_write(logic [CFG_ADDR_BITS-1:0] addr, logic [31:0] data);
        @(negedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= data; penable <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == ADDR_LEVEL) level_q = data[VB-1:0];
        else if (addr == ADDR_FLOOR) floor_q = data[VB:0];
    endtask

    // Waits until the block has returned everything sent so far.
    task automatic drain();
        while (cells_pending.size() > 0 || s_tvalid || segs_expected.size() > 0)
            @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    function automatic logic [VB-1:0] rand_value();
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            2: return level_q;
            3: return level_q - 1'b1;
            default: return VB'($urandom);
        endcase
    endfunction

    function automatic logic [CB-1:0] rand_coord();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'($urandom_range(2000)) - 32'd1000;
            default: return $urandom;
        endcase
    endfunction

    function automatic cell_t rand_cell();
        cell_t c;
        c.tag = 16'($urandom);
        c.v_tl = rand_value(); c.v_tr = rand_value();
        c.v_br = rand_value(); c.v_bl = rand_value();
        c.left_x = rand_coord(); c.right_x = rand_coord();
        c.top_y = rand_coord(); c.bottom_y = rand_coord();
        return c;
    endfunction

    task automatic add_random(int count);
        repeat (count) cells_pending.push_back(rand_cell());
    endtask

    initial begin
        cell_t c;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: every case at reset settings, then field extremes.
        for (int cs = 0; cs < 16; cs++) begin
            c = rand_cell();
            c.v_tl = cs[0] ? 16'hffff : 16'd0;
            c.v_tr = cs[1] ? 16'd32768 : 16'd32767;
            c.v_br = cs[2] ? 16'd40000 : 16'd100;
            c.v_bl = cs[3] ? 16'd50000 : 16'd1;
            cells_pending.push_back(c);
        end
        c = '1;
        cells_pending.push_back(c);
        c = '0;
        cells_pending.push_back(c);
        c = rand_cell();
        c.left_x = 32'h8000_0000; c.right_x = 32'h7fff_ffff;
        c.top_y = 32'h7fff_ffff; c.bottom_y = 32'h8000_0000;
        c.v_tl = 16'hffff; c.v_tr = 16'd1; c.v_br = 16'hffff; c.v_bl = 16'd1;
        cells_pending.push_back(c);
        drain();

        // Zero weight sums with the floor disabled, and a floor above every sum.
        reg_write(ADDR_FLOOR, 32'd0);
        reg_write(ADDR_LEVEL, 32'd0);
        c = rand_cell();
        c.v_tl = 0; c.v_tr = 0; c.v_br = 0; c.v_bl = 0;
        cells_pending.push_back(c);
        add_random(4);
        drain();
        reg_write(ADDR_FLOOR, 32'hffff_ffff);
        reg_write(ADDR_LEVEL, 32'hffff_ffff);
        add_random(5);
        drain();

        // Random phases: receiver-limited, sender-limited, then full rate.
        reg_write(ADDR_LEVEL, 32'd32768);
        reg_write(ADDR_FLOOR, 32'd1);
        send_idle_pct = 17; recv_idle_pct = 57;
        add_random(600);
        drain();

        reg_write(ADDR_LEVEL, 32'd1);
        reg_write(ADDR_FLOOR, 32'd40000);
        send_idle_pct = 57; recv_idle_pct = 17;
        add_random(600);
        drain();

        reg_write(ADDR_LEVEL, 32'($urandom));
        reg_write(ADDR_FLOOR, 32'($urandom_range(131071)));
        send_idle_pct = 0; recv_idle_pct = 0;
        hold_cycles = 200;   // long receiver stall so the input backs up
        add_random(750);
        drain();

        $display("Sent %0d cells, checked %0d results (%0d saddle cells),",
                 cells_sent, segs_checked, saddles_seen);
        $display("over several threshold and floor settings and idle patterns.");
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // A stalled run ends here instead.
    always @(posedge aclk) begin
        if (timed_out) begin
            $display("Watchdog expired with %0d results outstanding.",
                     segs_expected.size());
            $display("Test completed with failures");
            $finish;
        end
    end
endmodule
